// ===== sv/pal_pkg.sv =====
// Shared types and constants of the positional array list.
package pal_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CNT_W  = 5;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic signed [DATA_W-1:0] NO_DATA = '1;

  typedef struct packed {
    logic             wr;
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] position;
  } pal_ctl_t;

endpackage

// ===== sv/pal_cell.sv =====
// One list cell: holds a single entry and shifts to or from its neighbours.
module pal_cell
  import pal_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic                     clk,
  input  pal_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] sel_data
);

  localparam bit               REACH     = (INDEX + 1) < (1 << POS_W);
  localparam logic [POS_W-1:0] SLOT_CODE = POS_W'(INDEX + 1);

  logic hit;
  logic above;

  assign hit   = REACH && (ctl.position == SLOT_CODE);
  assign above = !REACH || (SLOT_CODE > ctl.position);

  assign sel_data = hit ? data : '0;

  always_ff @(posedge clk) begin
    if (ctl.wr && hit) begin
      data <= new_value;
    end else if (ctl.ins && hit) begin
      data <= new_value;
    end else if (ctl.ins && above) begin
      data <= left_data;
    end else if (ctl.rem && (hit || above)) begin
      data <= right_data;
    end
  end

endmodule

// ===== sv/positional_array_list.sv =====
// Top level of the positional array list: a row of entry cells and the result register.
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_stall  req_type, position, new_value
//   result    out        rsp_valid / rsp_stall  read_data, status, entry_count,
//                                               is_empty, is_full
//
// Each request is decided and applied to every cell in the cycle it is accepted.
// The result follows in the next cycle: one request per cycle unless results stall.
// A stalled result holds the result register and stalls the request side.
// Reset empties the list at once; entry contents are not cleared.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] new_value,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [DATA_W-1:0] read_data,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     is_empty,
  output logic                     is_full
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic                     accept;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [WW-1:0]            pos_w;
  logic [WW-1:0]            cnt_w;
  logic                     in_span;
  logic                     ins_span;
  logic                     full_now;
  logic [1:0]               st_next;
  logic signed [DATA_W-1:0] data_next;
  logic signed [DATA_W-1:0] sel_or;
  pal_ctl_t                 ctl;

  logic signed [DATA_W-1:0] ent [CAPACITY];
  logic signed [DATA_W-1:0] sel [CAPACITY];

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign pos_w    = WW'(position);
  assign cnt_w    = WW'(count);
  assign in_span  = (position != '0) && (pos_w <= cnt_w);
  assign ins_span = (position != '0) && (pos_w <= cnt_w + WW'(1));
  assign full_now = (count == CW'(CAPACITY));

  always_comb begin
    st_next    = ST_OK;
    count_next = count;
    ctl.wr     = 1'b0;
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.position = position;
    case (req_type)
      OP_READ: begin
        if (!in_span) st_next = ST_BADPOS;
      end
      OP_WRITE: begin
        if (!in_span) st_next = ST_BADPOS;
        else ctl.wr = accept;
      end
      OP_INSERT: begin
        if (full_now) begin
          st_next = ST_FULL;
        end else if (!ins_span) begin
          st_next = ST_BADPOS;
        end else begin
          ctl.ins    = accept;
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (!in_span) begin
          st_next = ST_BADPOS;
        end else begin
          ctl.rem    = accept;
          count_next = count - CW'(1);
        end
      end
      default: st_next = ST_BADPOS;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = new_value;
      end else begin : g_mid
        assign left_d = ent[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = ent[g];
      end else begin : g_inner
        assign right_d = ent[g+1];
      end
      pal_cell #(.INDEX(g)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_value  (new_value),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (ent[g]),
        .sel_data   (sel[g])
      );
    end
  endgenerate

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_or = sel_or | sel[i];
    end
  end

  assign data_next = ((st_next == ST_OK) &&
                      ((req_type == OP_READ) || (req_type == OP_REMOVE))) ? sel_or : NO_DATA;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= data_next;
      status      <= st_next;
      entry_count <= CNT_W'(count_next);
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == CW'(CAPACITY));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.ins |=> count == $past(count) + CW'(1))
    else $error("successful insert did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> is_full && (read_data == NO_DATA))
    else $error("full status without a full list");

  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (st_next != ST_OK) |=> count == $past(count))
    else $error("failed request changed the entry count");

endmodule

// ===== test/pal_list_checker.sv =====
// Checker for the positional array list: predicts each request's result and compares it.
module pal_list_checker
  import pal_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic                     req_stall,
  input  logic [1:0]               req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic                     rsp_valid,
  input  logic                     rsp_stall,
  input  logic signed [DATA_W-1:0] read_data,
  input  logic [1:0]               status,
  input  logic [CNT_W-1:0]         entry_count,
  input  logic                     is_empty,
  input  logic                     is_full,
  output int unsigned              pending,
  output int unsigned              fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               st;
    logic [CNT_W-1:0]         cnt;
    logic                     empty;
    logic                     full;
  } list_result_t;

  logic signed [DATA_W-1:0] list_entries [CAPACITY];
  int                       list_len = 0;
  list_result_t             expected_results [$];

  initial begin
    foreach (list_entries[k]) list_entries[k] = '0;
  end

  function automatic list_result_t apply_list_request(input logic [1:0] op,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           p;
    int           i;
    res.data = NO_DATA;
    res.st   = ST_OK;
    p        = int'(pos);
    case (op)
      OP_READ, OP_WRITE: begin
        if (p >= 1 && p <= list_len) begin
          if (op == OP_READ) begin
            res.data = list_entries[p-1];
          end else begin
            list_entries[p-1] = val;
          end
        end else begin
          res.st = ST_BADPOS;
        end
      end
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.st = ST_FULL;
        end else if (p >= 1 && p <= list_len + 1) begin
          for (i = list_len; i >= p; i--) list_entries[i] = list_entries[i-1];
          list_entries[p-1] = val;
          list_len++;
        end else begin
          res.st = ST_BADPOS;
        end
      end
      default: begin
        if (p >= 1 && p <= list_len) begin
          res.data = list_entries[p-1];
          for (i = p - 1; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
          list_len--;
        end else begin
          res.st = ST_BADPOS;
        end
      end
    endcase
    res.cnt   = CNT_W'(list_len);
    res.empty = (list_len == 0);
    res.full  = (list_len == CAPACITY);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result expected none, actual data %0h status %0d count %0d",
                   $time, read_data, status, entry_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.data, read_data);
          check_field("status", DATA_W'(want.st), DATA_W'(status));
          check_field("entry_count", DATA_W'(want.cnt), DATA_W'(entry_count));
          check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
          check_field("is_full", DATA_W'(want.full), DATA_W'(is_full));
        end
      end
      if (req_valid && !req_stall) begin
        expected_results.push_back(apply_list_request(req_type, position, new_value));
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== test/tb_positional_array_list.sv =====
// Testbench top of the positional array list: stimulus, receiver stalls, watchdog and verdict.
module tb_positional_array_list;
  import pal_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY      = 16;
  localparam int HOLD_CYCLES   = 40;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 200;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     req_valid   = 1'b0;
  logic                     req_stall;
  logic [1:0]               req_type    = OP_READ;
  logic [POS_W-1:0]         position    = '0;
  logic signed [DATA_W-1:0] new_value   = '0;
  logic                     rsp_valid;
  logic                     rsp_stall   = 1'b0;
  logic signed [DATA_W-1:0] read_data;
  logic [1:0]               status;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic                     is_full;

  int unsigned pending;
  int unsigned fail_count;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_toggle    = 1'b0;
  bit          hold_seen      = 1'b0;
  int          list_fill      = 0;
  bit          draining       = 1'b0;
  int          quiet_cycles   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  positional_array_list #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .position(position), .new_value(new_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .read_data(read_data), .status(status), .entry_count(entry_count),
    .is_empty(is_empty), .is_full(is_full)
  );

  pal_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .position(position), .new_value(new_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .read_data(read_data), .status(status), .entry_count(entry_count),
    .is_empty(is_empty), .is_full(is_full),
    .pending(pending), .fail_count(fail_count)
  );

  task automatic send_request(input logic [1:0] op, input int pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= op;
    position  <= POS_W'(pos);
    new_value <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (op == OP_INSERT && list_fill < CAPACITY && pos >= 1 && pos <= list_fill + 1) begin
      list_fill++;
    end else if (op == OP_REMOVE && pos >= 1 && pos <= list_fill) begin
      list_fill--;
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_request();
    logic [1:0] op;
    int         pos;
    int         r;
    if (list_fill == CAPACITY) begin
      draining = 1'b1;
    end else if (list_fill == 0) begin
      draining = 1'b0;
    end else if ($urandom_range(99) < 3) begin
      draining = !draining;
    end
    r = $urandom_range(99);
    if (draining) begin
      op = (r < 50) ? OP_REMOVE : (r < 65) ? OP_INSERT : (r < 85) ? OP_READ : OP_WRITE;
    end else begin
      op = (r < 50) ? OP_INSERT : (r < 65) ? OP_REMOVE : (r < 85) ? OP_READ : OP_WRITE;
    end
    if ($urandom_range(99) < 10 || (list_fill == 0 && op != OP_INSERT)) begin
      pos = $urandom_range(31);
    end else if (op == OP_INSERT) begin
      pos = $urandom_range(list_fill + 1, 1);
    end else begin
      pos = $urandom_range(list_fill, 1);
    end
    send_request(op, pos, $urandom());
  endtask

  initial begin
    forever begin
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("positional_array_list: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_READ, 1, 0);
    send_request(OP_REMOVE, 1, 0);
    send_request(OP_WRITE, 0, 32'h5a5a5a5a);
    send_request(OP_INSERT, 0, 1);
    send_request(OP_INSERT, 2, 2);
    send_request(OP_INSERT, 1, 32'h7fffffff);
    send_request(OP_INSERT, 1, 32'h80000000);
    send_request(OP_INSERT, 3, 0);
    send_request(OP_INSERT, 2, -1);
    send_request(OP_INSERT, 6, 3);
    send_request(OP_READ, 4, 0);
    send_request(OP_READ, 5, 0);
    send_request(OP_WRITE, 2, 32'h12345678);
    send_request(OP_READ, 2, 0);
    send_request(OP_REMOVE, 2, 0);
    send_request(OP_REMOVE, 0, 0);
    send_request(OP_READ, 31, 0);
    while (list_fill < CAPACITY) send_request(OP_INSERT, $urandom_range(list_fill + 1, 1), $urandom());
    send_request(OP_INSERT, 0, 7);
    send_request(OP_INSERT, 31, 7);
    send_request(OP_READ, 16, 0);
    send_request(OP_WRITE, 17, 0);
    send_request(OP_REMOVE, 16, 0);
    send_request(OP_REMOVE, 1, 0);
    send_request(OP_READ, 1, 0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 34 : 0;
      recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 34 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 60) hold_toggle = !hold_toggle;
        random_request();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_array_list: match");
    end else begin
      $display("positional_array_list: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pal_pkg.sv
sv/pal_cell.sv
sv/positional_array_list.sv
test/pal_list_checker.sv
test/tb_positional_array_list.sv
